/* hdl/spritz_pkg.sv */
package spritz_pkg;

    localparam int PERM_SIZE = 256;

    localparam logic [7:0] HALF_IDX   = 8'(PERM_SIZE / 2);
    localparam logic [7:0] PERM_LAST  = 8'(PERM_SIZE - 1);
    localparam logic [8:0] WHIP_LAST  = 9'(PERM_SIZE * 2 - 1);
    localparam logic [6:0] CRUSH_LAST = 7'(PERM_SIZE / 2 - 1);
    localparam logic [7:0] W_INIT     = 8'd1;
    localparam logic [7:0] W_STEP     = 8'd2;

    // item kinds
    typedef enum logic [1:0] {
        KIND_START   = 2'd0,
        KIND_ABSORB  = 2'd1,
        KIND_STOP    = 2'd2,
        KIND_PROCESS = 2'd3
    } kind_t;

    // combine modes
    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_XOR = 2'd2,
        MODE_RAW = 2'd3
    } mode_t;

    localparam logic [2:0] PH_WHIP0  = 3'd0;
    localparam logic [2:0] PH_CRUSH0 = 3'd1;
    localparam logic [2:0] PH_WHIP1  = 3'd2;
    localparam logic [2:0] PH_CRUSH1 = 3'd3;
    localparam logic [2:0] PH_WHIP2  = 3'd4;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_SHUF_NEXT,
        ST_ADV_RI,
        ST_ADV_RJ,
        ST_ADV_RK,
        ST_ADV_W1,
        ST_ADV_W2,
        ST_CR_RV,
        ST_CR_RU,
        ST_CR_CMP,
        ST_CR_W2,
        ST_AB_RA,
        ST_AB_RX,
        ST_AB_W1,
        ST_AB_W2,
        ST_DR_R1,
        ST_DR_R2,
        ST_DR_R3,
        ST_DR_LATCH,
        ST_DR_EMIT
    } state_t;

    typedef struct packed {
        logic       we;
        logic [7:0] waddr;
        logic [7:0] wdata;
        logic [7:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] ks;
        logic [7:0] data;
    } drip_t;

endpackage

/* hdl/spritz_sponge_cipher.sv */
// Spritz sponge stream engine over a 256-byte permutation held in one
// synchronous-read memory. The item kind travels in s_tuser: start (fresh
// identity state, i=j=k=z=a=0, w=1), absorb byte (low nibble, then high),
// absorb stop (pad) and process byte. Only process items return an item on
// the m_ side: the keystream byte added to, subtracted from or XORed with
// the data byte, or the raw keystream byte, as cfg_wr_data selects (reset
// is XOR). Every memory read goes through the single registered read
// port, so the item timing is set by those dependent reads.
// When absorbed nibbles or pads are pending, the next process item first
// runs a shuffle (three whips of 512 advances, two crushes of 128 pairs);
// an absorb or stop item that finds the counter at 128 runs the same
// shuffle. After reset, and after each start item, a sweep over all 256
// entries loads the identity permutation, during which s_tready stays
// low. The host sequences key setup, hashing and the squeeze length; no
// squeeze limit is enforced here.
module spritz_sponge_cipher (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration: combine mode
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data,
    // input items
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic [1:0] s_tuser,   // [1:0] kind
    // result items
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [7:0] out_byte
);
    import spritz_pkg::*;

    mode_t      mode_reg;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_data_reg, m_data_next;
    logic [7:0] combined;
    logic       drip_ready;
    mem_req_t   mem_req;
    logic [7:0] mem_rdata;
    drip_t      drip;

    // sequencer: index registers, absorb counter and all permutation walks
    spritz_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (s_tvalid),
        .item_ready (s_tready),
        .item_kind  (s_tuser),
        .item_data  (s_tdata),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata),
        .drip       (drip),
        .drip_ready (drip_ready)
    );

    // permutation store, one write and one registered read per cycle
    spritz_perm_mem u_mem (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // combine mode register; the user writes it only while the engine is idle, the block does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_XOR;
        end else if (cfg_wr_en) begin
            mode_reg <= mode_t'(cfg_wr_data);
        end
    end

    // keystream combine, all mod 256
    always_comb begin
        unique case (mode_reg)
            MODE_ADD: combined = drip.data + drip.ks;
            MODE_SUB: combined = drip.data - drip.ks;
            MODE_XOR: combined = drip.data ^ drip.ks;
            MODE_RAW: combined = drip.ks;
            default:  combined = drip.ks;
        endcase
    end

    // output register decouples the sequencer from a stalled sink
    assign drip_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (drip.valid && drip_ready) begin
            m_valid_next = 1'b1;
            m_data_next  = combined;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

/* hdl/spritz_perm_mem.sv */
module spritz_perm_mem (
    input  logic                 aclk,
    input  spritz_pkg::mem_req_t req,
    output logic [7:0]           rdata
);
    import spritz_pkg::*;

    logic [7:0] mem [PERM_SIZE];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/spritz_seq.sv */
module spritz_seq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic [1:0]           item_kind,
    input  logic [7:0]           item_data,
    output spritz_pkg::mem_req_t mem_req,
    input  logic [7:0]           mem_rdata,
    output spritz_pkg::drip_t    drip,
    input  logic                 drip_ready
);
    import spritz_pkg::*;

    state_t     state_reg, state_next;
    logic [7:0] i_reg, i_next;
    logic [7:0] j_reg, j_next;
    logic [7:0] k_reg, k_next;
    logic [7:0] z_reg, z_next;
    logic [7:0] a_reg, a_next;
    logic [7:0] w_reg, w_next;
    logic [7:0] tmp_reg, tmp_next;
    logic [8:0] cnt_reg, cnt_next;
    logic [2:0] phase_reg, phase_next;
    logic       shuf_reg, shuf_next;
    logic       nib_reg, nib_next;
    kind_t      kind_reg, kind_next;
    logic [7:0] data_reg, data_next;
    logic [7:0] nibble_addr;
    logic [7:0] crush_v, crush_u;

    assign nibble_addr = HALF_IDX + {4'd0, (nib_reg ? data_reg[7:4] : data_reg[3:0])};
    assign crush_v     = {1'b0, cnt_reg[6:0]};
    assign crush_u     = PERM_LAST - crush_v;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            z_reg     <= '0;
            a_reg     <= '0;
            w_reg     <= W_INIT;
            cnt_reg   <= '0;
            phase_reg <= '0;
            shuf_reg  <= 1'b0;
            nib_reg   <= 1'b0;
            kind_reg  <= KIND_START;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            z_reg     <= z_next;
            a_reg     <= a_next;
            w_reg     <= w_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
            shuf_reg  <= shuf_next;
            nib_reg   <= nib_next;
            kind_reg  <= kind_next;
        end
    end

    always_ff @(posedge aclk) begin
        tmp_reg  <= tmp_next;
        data_reg <= data_next;
    end

    always_comb begin
        state_next    = state_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        z_next        = z_reg;
        a_next        = a_reg;
        w_next        = w_reg;
        tmp_next      = tmp_reg;
        cnt_next      = cnt_reg;
        phase_next    = phase_reg;
        shuf_next     = shuf_reg;
        nib_next      = nib_reg;
        kind_next     = kind_reg;
        data_next     = data_reg;
        mem_req       = '0;
        item_ready    = 1'b0;
        drip.valid    = 1'b0;
        drip.ks       = z_reg;
        drip.data     = data_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = cnt_reg[7:0];
                mem_req.wdata = cnt_reg[7:0];
                cnt_next      = cnt_reg + 9'd1;
                if (cnt_reg[7:0] == PERM_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                item_ready = 1'b1;
                if (item_valid) begin
                    kind_next = kind_t'(item_kind);
                    data_next = item_data;
                    nib_next  = 1'b0;
                    if (kind_t'(item_kind) == KIND_START) begin
                        i_next     = '0;
                        j_next     = '0;
                        k_next     = '0;
                        z_next     = '0;
                        a_next     = '0;
                        w_next     = W_INIT;
                        cnt_next   = '0;
                        state_next = ST_CLEAR;
                    end else begin
                        state_next = ST_DISPATCH;
                    end
                end
            end
            ST_DISPATCH: begin
                case (kind_reg)
                    KIND_PROCESS: begin
                        if (a_reg != 8'd0) begin
                            shuf_next  = 1'b1;
                            phase_next = PH_WHIP0;
                            state_next = ST_SHUF_NEXT;
                        end else begin
                            state_next = ST_ADV_RI;
                        end
                    end
                    KIND_ABSORB: begin
                        if (a_reg == HALF_IDX) begin
                            shuf_next  = 1'b1;
                            phase_next = PH_WHIP0;
                            state_next = ST_SHUF_NEXT;
                        end else begin
                            state_next = ST_AB_RA;
                        end
                    end
                    default: begin
                        if (a_reg == HALF_IDX) begin
                            shuf_next  = 1'b1;
                            phase_next = PH_WHIP0;
                            state_next = ST_SHUF_NEXT;
                        end else begin
                            a_next     = a_reg + 8'd1;
                            state_next = ST_IDLE;
                        end
                    end
                endcase
            end
            ST_SHUF_NEXT: begin
                cnt_next = '0;
                case (phase_reg)
                    PH_WHIP0, PH_WHIP1, PH_WHIP2: state_next = ST_ADV_RI;
                    PH_CRUSH0, PH_CRUSH1:         state_next = ST_CR_RV;
                    default: begin
                        shuf_next  = 1'b0;
                        a_next     = '0;
                        state_next = ST_DISPATCH;
                    end
                endcase
            end
            // one advance: i += w, j = k + S[j + S[i]], k = i + k + S[j], swap S[i], S[j]
            ST_ADV_RI: begin
                i_next        = i_reg + w_reg;
                mem_req.raddr = i_reg + w_reg;
                state_next    = ST_ADV_RJ;
            end
            ST_ADV_RJ: begin
                tmp_next      = mem_rdata;
                mem_req.raddr = j_reg + mem_rdata;
                state_next    = ST_ADV_RK;
            end
            ST_ADV_RK: begin
                j_next        = k_reg + mem_rdata;
                mem_req.raddr = k_reg + mem_rdata;
                state_next    = ST_ADV_W1;
            end
            ST_ADV_W1: begin
                k_next        = i_reg + k_reg + mem_rdata;
                mem_req.we    = 1'b1;
                mem_req.waddr = i_reg;
                mem_req.wdata = mem_rdata;
                state_next    = ST_ADV_W2;
            end
            ST_ADV_W2: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = j_reg;
                mem_req.wdata = tmp_reg;
                if (shuf_reg) begin
                    if (cnt_reg == WHIP_LAST) begin
                        w_next     = w_reg + W_STEP;
                        phase_next = phase_reg + 3'd1;
                        state_next = ST_SHUF_NEXT;
                    end else begin
                        cnt_next   = cnt_reg + 9'd1;
                        state_next = ST_ADV_RI;
                    end
                end else begin
                    state_next = ST_DR_R1;
                end
            end
            // crush: order the pair S[v], S[N-1-v]
            ST_CR_RV: begin
                mem_req.raddr = crush_v;
                state_next    = ST_CR_RU;
            end
            ST_CR_RU: begin
                tmp_next      = mem_rdata;
                mem_req.raddr = crush_u;
                state_next    = ST_CR_CMP;
            end
            ST_CR_CMP: begin
                if (tmp_reg > mem_rdata) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = crush_v;
                    mem_req.wdata = mem_rdata;
                    state_next    = ST_CR_W2;
                end else if (cnt_reg[6:0] == CRUSH_LAST) begin
                    phase_next = phase_reg + 3'd1;
                    state_next = ST_SHUF_NEXT;
                end else begin
                    cnt_next   = cnt_reg + 9'd1;
                    state_next = ST_CR_RV;
                end
            end
            ST_CR_W2: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = crush_u;
                mem_req.wdata = tmp_reg;
                if (cnt_reg[6:0] == CRUSH_LAST) begin
                    phase_next = phase_reg + 3'd1;
                    state_next = ST_SHUF_NEXT;
                end else begin
                    cnt_next   = cnt_reg + 9'd1;
                    state_next = ST_CR_RV;
                end
            end
            // absorb one nibble: swap S[a], S[N/2 + x]
            ST_AB_RA: begin
                mem_req.raddr = a_reg;
                state_next    = ST_AB_RX;
            end
            ST_AB_RX: begin
                tmp_next      = mem_rdata;
                mem_req.raddr = nibble_addr;
                state_next    = ST_AB_W1;
            end
            ST_AB_W1: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = a_reg;
                mem_req.wdata = mem_rdata;
                state_next    = ST_AB_W2;
            end
            ST_AB_W2: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = nibble_addr;
                mem_req.wdata = tmp_reg;
                a_next        = a_reg + 8'd1;
                if (nib_reg) begin
                    state_next = ST_IDLE;
                end else begin
                    nib_next   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            // z = S[j + S[i + S[z + k]]]
            ST_DR_R1: begin
                mem_req.raddr = z_reg + k_reg;
                state_next    = ST_DR_R2;
            end
            ST_DR_R2: begin
                mem_req.raddr = i_reg + mem_rdata;
                state_next    = ST_DR_R3;
            end
            ST_DR_R3: begin
                mem_req.raddr = j_reg + mem_rdata;
                state_next    = ST_DR_LATCH;
            end
            ST_DR_LATCH: begin
                z_next     = mem_rdata;
                state_next = ST_DR_EMIT;
            end
            ST_DR_EMIT: begin
                drip.valid = 1'b1;
                if (drip_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* tb/sv/spritz_sponge_cipher_checker.sv */
`timescale 1ns / 1ps

module spritz_sponge_cipher_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic [1:0] s_tuser,   // [1:0] kind
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [7:0] out_byte
    output int         errors,
    output int         pending
);
    import spritz_pkg::*;

    logic [7:0] perm [PERM_SIZE];
    logic [7:0] ri, rj, rk, rz, ra, rw;
    mode_t      mode;
    logic [7:0] expected_out [$];

    initial errors = 0;

    function automatic void swap_perm(input logic [7:0] p, input logic [7:0] q);
        logic [7:0] t;
        t = perm[p];
        perm[p] = perm[q];
        perm[q] = t;
    endfunction

    function automatic void fresh_perm();
        for (int v = 0; v < PERM_SIZE; v++) perm[v] = 8'(v);
        ri = '0;
        rj = '0;
        rk = '0;
        rz = '0;
        ra = '0;
        rw = W_INIT;
    endfunction

    function automatic void advance_ptrs();
        ri = ri + rw;
        rj = rk + perm[8'(rj + perm[ri])];
        rk = ri + rk + perm[rj];
        swap_perm(ri, rj);
    endfunction

    function automatic void whip_perm();
        for (int v = 0; v < 2 * PERM_SIZE; v++) advance_ptrs();
        rw = rw + W_STEP;
    endfunction

    function automatic void crush_perm();
        int u;
        for (int v = 0; v < PERM_SIZE / 2; v++) begin
            u = PERM_SIZE - 1 - v;
            if (perm[v] > perm[u]) swap_perm(8'(v), 8'(u));
        end
    endfunction

    function automatic void shuffle_perm();
        whip_perm();
        crush_perm();
        whip_perm();
        crush_perm();
        whip_perm();
        ra = '0;
    endfunction

    function automatic void mix_nibble(input logic [3:0] x);
        if (ra == HALF_IDX) shuffle_perm();
        swap_perm(ra, HALF_IDX + {4'd0, x});
        ra = ra + 8'd1;
    endfunction

    function automatic void absorb_pad();
        if (ra == HALF_IDX) shuffle_perm();
        ra = ra + 8'd1;
    endfunction

    function automatic logic [7:0] drip_keystream();
        if (ra != 8'd0) shuffle_perm();
        advance_ptrs();
        rz = perm[8'(rj + perm[8'(ri + perm[8'(rz + rk)])])];
        return rz;
    endfunction

    function automatic logic [7:0] combine_byte(input mode_t m, input logic [7:0] d,
                                                input logic [7:0] ks);
        case (m)
            MODE_ADD: return d + ks;
            MODE_SUB: return d - ks;
            MODE_XOR: return d ^ ks;
            default:  return ks;
        endcase
    endfunction

    always @(posedge aclk) begin : watch
        logic [7:0] want;
        if (!aresetn) begin
            fresh_perm();
            mode = MODE_XOR;
            expected_out.delete();
        end else begin
            if (cfg_wr_en) mode = mode_t'(cfg_wr_data);
            if (m_tvalid && m_tready) begin
                if (expected_out.size() == 0) begin
                    $display("%0t: unexpected out_byte, expected none, actual %02h",
                             $time, m_tdata);
                    errors++;
                end else begin
                    want = expected_out.pop_front();
                    if (m_tdata !== want) begin
                        $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                                 $time, want, m_tdata);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                case (kind_t'(s_tuser))
                    KIND_START: fresh_perm();
                    KIND_ABSORB: begin
                        mix_nibble(s_tdata[3:0]);
                        mix_nibble(s_tdata[7:4]);
                    end
                    KIND_STOP: absorb_pad();
                    default: expected_out.push_back(combine_byte(mode, s_tdata,
                                                                 drip_keystream()));
                endcase
            end
        end
        pending <= expected_out.size();
    end

endmodule

/* tb/sv/spritz_sponge_cipher_tb.sv */
`timescale 1ns / 1ps

module spritz_sponge_cipher_tb;
    import spritz_pkg::*;

    // a trailing shuffle may keep the block busy after the last expected item
    // has come out, so settle() waits SETTLE_CYCLES on top of the drain
    localparam int SETTLE_CYCLES = 9000;
    // long receiver hold-off, enough to back the block up into s_tready
    localparam int HOLD_CYCLES   = 600;
    // watchdog bound, set high enough to hold even if every item ran a shuffle
    localparam int CYCLE_LIMIT   = 30_000_000;
    localparam int PHASE_ITEMS   = 230;

    logic       aclk;
    logic       aresetn;
    logic       cfg_wr_en;
    logic [1:0] cfg_wr_data;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] data_byte
    logic [1:0] s_tuser;   // [1:0] kind
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [7:0] out_byte

    int errors;
    int pending;
    int send_idle;
    int recv_idle;
    int items_sent;
    int cycles;
    int hold_seq;
    int hold_done;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    spritz_sponge_cipher dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    spritz_sponge_cipher_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .errors      (errors),
        .pending     (pending)
    );

    // watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin
        m_tready = 1'b0;
        hold_done = 0;
        forever begin
            @(negedge aclk);
            if (hold_seq != hold_done) begin
                hold_done = hold_seq;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // offer one item, with random gaps first, and wait until it is taken;
    // tvalid is left high so back-to-back items never drop it in between
    task automatic send_item(input kind_t kind, input logic [7:0] data);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // stop sending, let every expected item drain, then let a trailing
    // shuffle finish so the block is idle
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mode(input mode_t m);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic absorb_bytes(input int n);
        repeat (n) send_item(KIND_ABSORB, 8'($urandom_range(0, 255)));
    endtask

    task automatic process_bytes(input int n);
        repeat (n) send_item(KIND_PROCESS, 8'($urandom_range(0, 255)));
    endtask

    // one well-formed use: fresh state, key absorb with the odd pad,
    // a keystream run, sometimes a re-key mid-stream, then a little noise
    task automatic key_and_stream();
        int n;
        if ($urandom_range(0, 99) < 85) send_item(KIND_START, 8'($urandom_range(0, 255)));
        n = $urandom_range(1, 6);
        repeat (n) begin
            if ($urandom_range(0, 99) < 12) send_item(KIND_STOP, 8'($urandom_range(0, 255)));
            absorb_bytes(1);
        end
        if ($urandom_range(0, 99) < 30) send_item(KIND_STOP, 8'($urandom_range(0, 255)));
        process_bytes($urandom_range(4, 30));
        // absorb after process forces another shuffle on the next drip
        if ($urandom_range(0, 99) < 20) begin
            absorb_bytes($urandom_range(1, 3));
            process_bytes($urandom_range(2, 10));
        end
        // noise: any kind, any byte
        repeat ($urandom_range(0, 2)) begin
            if ($urandom_range(0, 99) < 40)
                send_item(kind_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
    endtask

    // fill the absorb counter to its limit so a shuffle runs inside an absorb byte or pad
    task automatic long_absorb(input int n_bytes, input bit pad_after);
        send_item(KIND_START, 8'($urandom_range(0, 255)));
        absorb_bytes(n_bytes);
        if (pad_after) send_item(KIND_STOP, 8'($urandom_range(0, 255)));
        absorb_bytes(1);
        process_bytes(8);
    endtask

    task automatic run_phase(input int s_idle, input int r_idle, input int n_bytes,
                             input bit pad_after, input bit squeeze_hold);
        int first;
        settle();
        write_mode(mode_t'($urandom_range(0, 3)));
        send_idle = s_idle;
        recv_idle = r_idle;
        first = items_sent;
        long_absorb(n_bytes, pad_after);
        if (squeeze_hold) begin
            // receiver stalls long while a plain keystream run keeps coming
            @(negedge aclk);
            hold_seq <= hold_seq + 1;
            send_item(KIND_START, 8'($urandom_range(0, 255)));
            process_bytes(60);
        end
        while (items_sent - first < PHASE_ITEMS) key_and_stream();
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'd0;
        s_tuser     = KIND_START;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = MODE_XOR;
        send_idle   = 0;
        recv_idle   = 0;
        items_sent  = 0;
        hold_seq    = 0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // process with no start, reset mode is xor
        send_item(KIND_PROCESS, 8'h00);
        send_item(KIND_PROCESS, 8'hFF);

        // add mode: full key schedule with pad, then absorb after process
        settle();
        write_mode(MODE_ADD);
        send_item(KIND_START,   8'h00);
        send_item(KIND_ABSORB,  8'h00);
        send_item(KIND_ABSORB,  8'hFF);
        send_item(KIND_STOP,    8'h00);
        send_item(KIND_ABSORB,  8'hA5);
        send_item(KIND_PROCESS, 8'hFF);
        send_item(KIND_PROCESS, 8'h01);
        send_item(KIND_ABSORB,  8'h5A);
        send_item(KIND_PROCESS, 8'h80);

        // sub mode: no absorb at all, then a lone pad
        settle();
        write_mode(MODE_SUB);
        send_item(KIND_START,   8'hFF);
        send_item(KIND_PROCESS, 8'h00);
        send_item(KIND_PROCESS, 8'hFF);
        send_item(KIND_STOP,    8'hFF);
        send_item(KIND_PROCESS, 8'h7F);

        // raw keystream, continuing state, then fresh
        settle();
        write_mode(MODE_RAW);
        send_item(KIND_PROCESS, 8'h00);
        send_item(KIND_PROCESS, 8'hFF);
        send_item(KIND_START,   8'h00);
        send_item(KIND_PROCESS, 8'h12);

        // random phases; each starts with the absorb counter hitting its
        // limit in a different way: at a pad, mid-item, at the first nibble
        run_phase(38, 54, 64, 1'b1, 1'b0);
        run_phase(54, 38, 63, 1'b1, 1'b0);
        run_phase(0, 0, 64, 1'b0, 1'b1);

        settle();
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
